// ===== hdl/fir_lowpass_convolver_assert.svh =====
// ----------------------------------------------------------------------------
// fir_lowpass_convolver_assert.svh
// Assertion macros shared by the convolver RTL.
// ----------------------------------------------------------------------------
`ifndef FIR_LOWPASS_CONVOLVER_ASSERT_SVH
`define FIR_LOWPASS_CONVOLVER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define FLC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define FLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/flc_pkg.sv =====
// ----------------------------------------------------------------------------
// flc_pkg
// Widths, sizes and codes for the FIR low-pass convolver.
// ----------------------------------------------------------------------------
package flc_pkg;

	// Filter length (1 to 32)
	localparam int TAPS     = 32;
	localparam int TAP_AW   = (TAPS > 1) ? $clog2(TAPS) : 1;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 24;
	localparam int CIDX_W   = 5;
	localparam int DIV_W    = 24;
	localparam int FRAC_W   = 8;

	// Datapath widths
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W    = PROD_W + TAP_AW;
	localparam int DVD_W    = ACC_W - FRAC_W;
	localparam int DCNT_W   = $clog2(DVD_W);

	// Input action codes
	localparam logic ACT_LOAD_COEF = 1'b0;
	localparam logic ACT_PUSH      = 1'b1;

endpackage

// ===== hdl/fir_lowpass_convolver.sv =====
// ----------------------------------------------------------------------------
// fir_lowpass_convolver
// Full linear convolution of 16-bit audio with a loaded tap table, normalised
// by the divisor register, saturated to 16 bits.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  item     | item_valid / item_stall    | action, coef_index, coef_value,
//           |                            | sample, last_sample
//  result   | result_valid / result_stall| filtered, clipped, last
//  divisor  | divisor_we                 | divisor_wdata
//
// A coefficient load is written to the tap table as it is accepted. A sample
// push runs these steps for each result: TAPS reads through the one shared
// multiply-accumulate plus its pipeline drain, then one quotient bit per cycle
// over DVD_W bits in the restoring divider, then a load into the output
// register. A last-marked sample gives TAPS results, each a full pass after
// the one before.
// Reset clears control, the divisor to 1 and the history valid bits.
// A stalled result holds the sequencer in its output state; the next result
// is computed while the previous one waits.
// ----------------------------------------------------------------------------
module fir_lowpass_convolver (
	input  logic                             clk,
	input  logic                             arst_n,
	// item channel
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             action,
	input  logic [flc_pkg::CIDX_W-1:0]       coef_index,
	input  logic signed [flc_pkg::COEF_W-1:0] coef_value,
	input  logic signed [flc_pkg::SAMPLE_W-1:0] sample,
	input  logic                             last_sample,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [flc_pkg::SAMPLE_W-1:0] filtered,
	output logic                             clipped,
	output logic                             last,
	// divisor register
	input  logic                             divisor_we,
	input  logic [flc_pkg::DIV_W-1:0]        divisor_wdata
);

	typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DIV, ST_OUT} state_t;

	state_t                              state_q;
	logic [flc_pkg::DIV_W-1:0]           divisor_q;

	// memories
	logic [flc_pkg::COEF_W-1:0]          tap_mem  [flc_pkg::TAPS];
	logic [flc_pkg::SAMPLE_W-1:0]        hist_mem [flc_pkg::TAPS];
	logic [flc_pkg::TAPS-1:0]            hist_vld_q;

	// sequencer
	logic [flc_pkg::TAP_AW-1:0]          wptr_q;
	logic [flc_pkg::TAP_AW-1:0]          rptr_q;
	logic [flc_pkg::TAP_AW-1:0]          iss_cnt_q;
	logic                                iss_done_q;
	logic                                flush_q;
	logic [flc_pkg::TAP_AW-1:0]          tail_q;
	logic [flc_pkg::DCNT_W-1:0]          div_cnt_q;
	logic                                v_s1;
	logic                                v_s2;

	// datapath
	logic signed [flc_pkg::COEF_W-1:0]   tap_s1;
	logic signed [flc_pkg::SAMPLE_W-1:0] hist_s1;
	logic                                hvld_s1;
	logic signed [flc_pkg::PROD_W-1:0]   prod_s2;
	logic signed [flc_pkg::ACC_W-1:0]    acc_q;
	logic [flc_pkg::DVD_W-1:0]           quo_q;
	logic [flc_pkg::DIV_W-1:0]           rem_q;
	logic                                neg_q;

	// output register
	logic                                out_valid_q;
	logic signed [flc_pkg::SAMPLE_W-1:0] filtered_q;
	logic                                clipped_q;
	logic                                last_q;

	// combinational
	logic                                item_acc;
	logic                                push_acc;
	logic                                load_acc;
	logic                                rd_en;
	logic                                mac_done;
	logic                                out_free;
	logic                                out_load;
	logic                                tail_shift;
	logic                                mac_start;
	logic [flc_pkg::TAP_AW-1:0]          wptr_dec;
	logic [flc_pkg::TAP_AW-1:0]          rptr_inc;
	logic [flc_pkg::ACC_W-1:0]           acc_mag;
	logic [flc_pkg::DIV_W-1:0]           div_eff;
	logic [flc_pkg::DIV_W:0]             trial;
	logic [flc_pkg::DIV_W:0]             diff;
	logic                                ge;
	logic                                big;
	logic                                pos_clip;
	logic                                neg_clip;
	logic signed [flc_pkg::SAMPLE_W-1:0] sat_val;
	logic                                sat_clip;

	// handshake decode
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign push_acc   = item_acc && (action == flc_pkg::ACT_PUSH);
	assign load_acc   = item_acc && (action == flc_pkg::ACT_LOAD_COEF) &&
	                    (32'(coef_index) < flc_pkg::TAPS);

	assign out_free   = !out_valid_q || !result_stall;
	assign out_load   = (state_q == ST_OUT) && out_free;
	assign tail_shift = out_load && flush_q && (tail_q != '0);
	assign mac_start  = push_acc || tail_shift;

	assign rd_en      = (state_q == ST_MAC) && !iss_done_q;
	assign mac_done   = (state_q == ST_MAC) && iss_done_q && !v_s1 && !v_s2;

	// circular pointer arithmetic, newest sample at wptr
	assign wptr_dec = (wptr_q == '0) ? flc_pkg::TAP_AW'(flc_pkg::TAPS - 1) : wptr_q - 1'b1;
	assign rptr_inc = (rptr_q == flc_pkg::TAP_AW'(flc_pkg::TAPS - 1)) ? '0 : rptr_q + 1'b1;

	// magnitude of the sum, fraction bits dropped before dividing
	assign acc_mag = acc_q[flc_pkg::ACC_W-1] ? flc_pkg::ACC_W'(-acc_q) : acc_q;

	// restoring divider step
	assign div_eff = (divisor_q == '0) ? flc_pkg::DIV_W'(1) : divisor_q;
	assign trial   = {rem_q, quo_q[flc_pkg::DVD_W-1]};
	assign diff    = trial - {1'b0, div_eff};
	assign ge      = (trial >= {1'b0, div_eff});

	// saturation of the signed quotient
	assign big      = |quo_q[flc_pkg::DVD_W-1:flc_pkg::SAMPLE_W];
	assign pos_clip = big || quo_q[flc_pkg::SAMPLE_W-1];
	assign neg_clip = big || (quo_q[flc_pkg::SAMPLE_W-1] && (|quo_q[flc_pkg::SAMPLE_W-2:0]));
	always_comb begin
		if (neg_q) begin
			sat_clip = neg_clip;
			sat_val  = neg_clip ? {1'b1, {(flc_pkg::SAMPLE_W-1){1'b0}}}
			                    : -$signed(quo_q[flc_pkg::SAMPLE_W-1:0]);
		end else begin
			sat_clip = pos_clip;
			sat_val  = pos_clip ? {1'b0, {(flc_pkg::SAMPLE_W-1){1'b1}}}
			                    : $signed(quo_q[flc_pkg::SAMPLE_W-1:0]);
		end
	end

	// divisor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= flc_pkg::DIV_W'(1);
		end else if (divisor_we) begin
			divisor_q <= divisor_wdata;
		end
	end

	// tap table
	always_ff @(posedge clk) begin
		if (load_acc) begin
			tap_mem[coef_index[flc_pkg::TAP_AW-1:0]] <= coef_value;
		end
		if (rd_en) begin
			tap_s1 <= tap_mem[iss_cnt_q];
		end
	end

	// sample history
	always_ff @(posedge clk) begin
		if (push_acc) begin
			hist_mem[wptr_dec] <= sample;
		end
		if (rd_en) begin
			hist_s1 <= hist_mem[rptr_q];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hist_vld_q  <= '0;
			wptr_q      <= '0;
			rptr_q      <= '0;
			iss_cnt_q   <= '0;
			iss_done_q  <= 1'b0;
			flush_q     <= 1'b0;
			tail_q      <= '0;
			div_cnt_q   <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			hvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			filtered_q  <= '0;
			clipped_q   <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			if (rd_en) begin
				hvld_s1 <= hist_vld_q[rptr_q];
			end
			if (out_free && !out_load) begin
				out_valid_q <= 1'b0;
			end

			// shift in a new sample or a flush zero
			if (mac_start) begin
				wptr_q               <= wptr_dec;
				rptr_q               <= wptr_dec;
				hist_vld_q[wptr_dec] <= push_acc;
				iss_cnt_q            <= '0;
				iss_done_q           <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (push_acc) begin
						flush_q <= last_sample;
						tail_q  <= last_sample ? flc_pkg::TAP_AW'(flc_pkg::TAPS - 1) : '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (rd_en) begin
						rptr_q    <= rptr_inc;
						iss_cnt_q <= iss_cnt_q + 1'b1;
						if (iss_cnt_q == flc_pkg::TAP_AW'(flc_pkg::TAPS - 1)) begin
							iss_done_q <= 1'b1;
						end
					end
					if (mac_done) begin
						div_cnt_q <= flc_pkg::DCNT_W'(flc_pkg::DVD_W - 1);
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						filtered_q  <= sat_val;
						clipped_q   <= sat_clip;
						last_q      <= flush_q && (tail_q == '0);
						if (tail_shift) begin
							tail_q  <= tail_q - 1'b1;
							state_q <= ST_MAC;
						end else begin
							if (flush_q) begin
								hist_vld_q <= '0;
							end
							flush_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// multiply-accumulate and divider datapath
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(hvld_s1 ? hist_s1 : '0) * tap_s1;
		if (mac_start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + flc_pkg::ACC_W'(prod_s2);
		end
		if (mac_done) begin
			quo_q <= acc_mag[flc_pkg::ACC_W-1:flc_pkg::FRAC_W];
			rem_q <= '0;
			neg_q <= acc_q[flc_pkg::ACC_W-1];
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[flc_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff[flc_pkg::DIV_W-1:0] : trial[flc_pkg::DIV_W-1:0];
		end
	end

	assign result_valid = out_valid_q;
	assign filtered     = filtered_q;
	assign clipped      = clipped_q;
	assign last         = last_q;

	// checks
`include "fir_lowpass_convolver_assert.svh"

	`FLC_ASSERT_NEXT(a_push_starts_mac, push_acc, state_q == ST_MAC, "push did not start MAC")
	`FLC_ASSERT_NOW(a_div_pipe_empty, state_q == ST_DIV, !v_s1 && !v_s2, "MAC not drained")
	`FLC_ASSERT_NOW(a_tail_only_flush, !flush_q, tail_q == '0, "tail count outside flush")
	`FLC_ASSERT_NEXT(a_final_clears, out_load && flush_q && (tail_q == '0),
		(hist_vld_q == '0) && (state_q == ST_IDLE) && last_q, "history not cleared after flush")

endmodule
